>>> sv/dhd_pkg.sv
// Package for the dual-header UART frame deframer.
// Holds the word and result types, header codes and frame length helpers.
// Has no dependencies; every other file of the block uses it.
package dhd_pkg;

    localparam int StoreDepth        = 12;
    localparam int PosW              = 4;
    localparam int DataFrameBytesDef = 12;
    localparam int EchoFrameBytesDef = 10;
    localparam int LenMin            = 4;
    localparam int LenMax            = 12;

    localparam logic [7:0] HdrDataA = 8'h5A;
    localparam logic [7:0] HdrDataB = 8'hA5;
    localparam logic [7:0] HdrEchoA = 8'hAA;
    localparam logic [7:0] HdrEchoB = 8'h55;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_DATA  = 2'd1,
        EV_ECHO  = 2'd2,
        EV_ERROR = 2'd3
    } t_event;

    typedef struct packed {
        logic       line_error;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        t_event      frame_event;
        logic [63:0] data_frame_low;
        logic [31:0] data_frame_high;
        logic [7:0]  echo_command;
        logic [15:0] received_bytes;
        logic [15:0] data_frames;
        logic [15:0] echo_frames;
        logic [15:0] line_errors;
    } t_result;

    function automatic logic [PosW-1:0] clamp_len(input int n);
        int c;
        c = (n < LenMin) ? LenMin : ((n > LenMax) ? LenMax : n);
        return PosW'(c);
    endfunction

endpackage

>>> sv/dhd_in_stage.sv
// Input register of the deframer: holds one received word until the engine takes it.
// Depends on dhd_pkg for the word type.
module dhd_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  dhd_pkg::t_item i_item,
    input  logic          i_take,
    output logic          o_valid,
    output dhd_pkg::t_item o_item
);

    logic           r_valid;
    dhd_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> sv/dhd_engine.sv
// Deframer state and the combinational logic that turns one word into one result.
// Holds the frame position, the frame bytes, the echoed command and the counters.
// Depends on dhd_pkg for types, header codes and the length clamp.
module dhd_engine #(
    parameter int DATA_FRAME_BYTES = dhd_pkg::DataFrameBytesDef,
    parameter int ECHO_FRAME_BYTES = dhd_pkg::EchoFrameBytesDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  dhd_pkg::t_item   i_item,
    output dhd_pkg::t_result o_result
);

    localparam logic [dhd_pkg::PosW-1:0] DataLen = dhd_pkg::clamp_len(DATA_FRAME_BYTES);
    localparam logic [dhd_pkg::PosW-1:0] EchoLen = dhd_pkg::clamp_len(ECHO_FRAME_BYTES);

    logic [dhd_pkg::PosW-1:0] r_pos, n_pos;
    logic [7:0]               r_store [dhd_pkg::StoreDepth];
    logic [7:0]               n_store [dhd_pkg::StoreDepth];
    logic [7:0]               r_last_echo, n_last_echo;
    logic [15:0]              r_byte_cnt, n_byte_cnt;
    logic [15:0]              r_data_cnt, n_data_cnt;
    logic [15:0]              r_echo_cnt, n_echo_cnt;
    logic [15:0]              r_err_cnt, n_err_cnt;
    logic [dhd_pkg::PosW-1:0] w_next_pos;
    logic                     w_start;
    logic                     w_hdr_match;
    dhd_pkg::t_event          w_event;
    logic [63:0]              w_low;
    logic [31:0]              w_high;
    logic [7:0]               w_b;

    assign w_b     = i_item.rx_byte;
    assign w_start = (w_b == dhd_pkg::HdrDataA) || (w_b == dhd_pkg::HdrEchoA);
    assign w_hdr_match = ((r_store[0] == dhd_pkg::HdrDataA) && (w_b == dhd_pkg::HdrDataB)) ||
                         ((r_store[0] == dhd_pkg::HdrEchoA) && (w_b == dhd_pkg::HdrEchoB));
    assign w_next_pos = r_pos + 1'b1;

    always_comb begin
        n_pos       = r_pos;
        n_store     = r_store;
        n_last_echo = r_last_echo;
        n_byte_cnt  = r_byte_cnt;
        n_data_cnt  = r_data_cnt;
        n_echo_cnt  = r_echo_cnt;
        n_err_cnt   = r_err_cnt;
        w_event     = dhd_pkg::EV_NONE;
        if (i_item.line_error) begin
            n_err_cnt = r_err_cnt + 16'd1;
            n_pos     = '0;
            w_event   = dhd_pkg::EV_ERROR;
        end else begin
            n_byte_cnt = r_byte_cnt + 16'd1;
            if (r_pos == '0) begin
                if (w_start) begin
                    n_store[0] = w_b;
                    n_pos      = dhd_pkg::PosW'(1);
                end
            end else if (r_pos == dhd_pkg::PosW'(1)) begin
                if (w_hdr_match) begin
                    n_store[1] = w_b;
                    n_pos      = dhd_pkg::PosW'(2);
                end else if (w_start) begin
                    n_store[0] = w_b;
                    n_pos      = dhd_pkg::PosW'(1);
                end else begin
                    n_pos = '0;
                end
            end else if (r_pos >= dhd_pkg::PosW'(dhd_pkg::StoreDepth)) begin
                n_pos = '0;
            end else begin
                n_store[r_pos] = w_b;
                if ((r_store[0] == dhd_pkg::HdrDataA) && (w_next_pos >= DataLen)) begin
                    n_data_cnt = r_data_cnt + 16'd1;
                    n_pos      = '0;
                    w_event    = dhd_pkg::EV_DATA;
                end else if ((r_store[0] == dhd_pkg::HdrEchoA) && (w_next_pos >= EchoLen)) begin
                    n_last_echo = n_store[3];
                    n_echo_cnt  = r_echo_cnt + 16'd1;
                    n_pos       = '0;
                    w_event     = dhd_pkg::EV_ECHO;
                end else if (w_next_pos >= dhd_pkg::PosW'(dhd_pkg::StoreDepth)) begin
                    n_pos = '0;
                end else begin
                    n_pos = w_next_pos;
                end
            end
        end
    end

    always_comb begin
        w_low  = '0;
        w_high = '0;
        for (int i = 0; i < 8; i++) begin
            if (dhd_pkg::PosW'(i) < DataLen) begin
                w_low[8*i +: 8] = n_store[i];
            end
        end
        for (int i = 8; i < dhd_pkg::StoreDepth; i++) begin
            if (dhd_pkg::PosW'(i) < DataLen) begin
                w_high[8*(i-8) +: 8] = n_store[i];
            end
        end
    end

    always_comb begin
        o_result.frame_event     = w_event;
        o_result.data_frame_low  = (w_event == dhd_pkg::EV_DATA) ? w_low : 64'd0;
        o_result.data_frame_high = (w_event == dhd_pkg::EV_DATA) ? w_high : 32'd0;
        o_result.echo_command    = n_last_echo;
        o_result.received_bytes  = n_byte_cnt;
        o_result.data_frames     = n_data_cnt;
        o_result.echo_frames     = n_echo_cnt;
        o_result.line_errors     = n_err_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_last_echo <= '0;
            r_byte_cnt  <= '0;
            r_data_cnt  <= '0;
            r_echo_cnt  <= '0;
            r_err_cnt   <= '0;
        end else if (i_step) begin
            r_pos       <= n_pos;
            r_last_echo <= n_last_echo;
            r_byte_cnt  <= n_byte_cnt;
            r_data_cnt  <= n_data_cnt;
            r_echo_cnt  <= n_echo_cnt;
            r_err_cnt   <= n_err_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_store <= n_store;
        end
    end

endmodule

>>> sv/dhd_out_stage.sv
// Result register of the deframer: holds one result word until the sink takes it.
// Depends on dhd_pkg for the result type.
module dhd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  dhd_pkg::t_result i_result,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_ready,
    output dhd_pkg::t_result o_result
);

    logic             r_valid;
    dhd_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

>>> sv/dual_header_uart_frame_deframer_top.sv
// Top level of the dual-header UART frame deframer.
// Instantiates dhd_in_stage, dhd_engine and dhd_out_stage; uses dhd_pkg.
//
// The block takes one received word per clock cycle while the output is not stalled,
// and returns exactly one result word for each through the input and result registers.
// A word passes an input register, combinational deframing logic that updates the frame
// position, frame bytes and counters, and a result register; the sustained rate of one
// word per cycle is set by that combinational state update. s_axis_tready follows
// m_axis_tready combinationally when both registers are full. A 5A A5 header opens a
// data frame and AA 55 opens an echo frame; a line error in tuser drops any partial
// frame and is not counted as a byte.
module dual_header_uart_frame_deframer_top #(
    parameter int DATA_FRAME_BYTES = dhd_pkg::DataFrameBytesDef,
    parameter int ECHO_FRAME_BYTES = dhd_pkg::EchoFrameBytesDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // rx_byte
    input  logic         s_axis_tuser,   // line_error
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // data_frame_low, data_frame_high, echo_command, received_bytes,
    // data_frames, echo_frames, line_errors
    output logic [167:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser    // frame_event
);

    dhd_pkg::t_item   w_in_item;
    dhd_pkg::t_item   w_item;
    dhd_pkg::t_result w_result;
    dhd_pkg::t_result w_out_result;
    logic             w_item_valid;
    logic             w_out_can_load;
    logic             w_step;

    assign w_in_item.rx_byte    = s_axis_tdata;
    assign w_in_item.line_error = s_axis_tuser;
    assign w_step               = w_item_valid && w_out_can_load;

    dhd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (w_in_item),
        .i_take  (w_step),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    dhd_engine #(
        .DATA_FRAME_BYTES (DATA_FRAME_BYTES),
        .ECHO_FRAME_BYTES (ECHO_FRAME_BYTES)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (w_item),
        .o_result (w_result)
    );

    dhd_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_step),
        .i_result   (w_result),
        .o_can_load (w_out_can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (w_out_result)
    );

    assign m_axis_tuser = w_out_result.frame_event;
    assign m_axis_tdata = {w_out_result.line_errors,
                           w_out_result.echo_frames,
                           w_out_result.data_frames,
                           w_out_result.received_bytes,
                           w_out_result.echo_command,
                           w_out_result.data_frame_high,
                           w_out_result.data_frame_low};

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    a_step_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> m_axis_tvalid)
        else $error("processed word produced no result word");

    a_error_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && w_item.line_error |=> m_axis_tuser == dhd_pkg::EV_ERROR)
        else $error("line error word did not give an error event");

    a_data_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != dhd_pkg::EV_DATA)
        |-> (m_axis_tdata[95:0] == 96'd0))
        else $error("data frame bytes nonzero outside a data event");

endmodule
